// File: hw/rtl/prmv_pkg.sv
`default_nettype none
package prmv_pkg;

  localparam int NUM_STATUSES_DEF = 8;
  localparam int COUNT_BITS_DEF   = 24;

  localparam int IDX_W     = 3;
  localparam int DELAY_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int MEAN_W    = 32;
  localparam int VAR_W     = 48;
  localparam int OUT_CNT_W = 24;
  localparam int SEEN_W    = 4;
  localparam int DIV_W     = 64;
  localparam int IN_DATA_W = 16;
  localparam int OUT_W     = 112;

  localparam int MEAN_LSB  = 0;
  localparam int VAR_LSB   = MEAN_LSB + MEAN_W;
  localparam int CNT_LSB   = VAR_LSB + VAR_W;
  localparam int FIRST_BIT = CNT_LSB + OUT_CNT_W;
  localparam int SEEN_LSB  = FIRST_BIT + 1;
  localparam int PAD_W     = OUT_W - SEEN_LSB - SEEN_W;

  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [VAR_W-1:0]  VAR_MAX  = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV1,
    ST_WAIT1,
    ST_DIV2,
    ST_WAIT2,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/prmv_ram.sv
`default_nettype none
module prmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/prmv_div.sv
`default_nettype none
module prmv_div #(
  parameter int DW = 64,
  parameter int SW = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [SW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] rem_nxt;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] quo_nxt;
  logic [SW:0]   sh;
  logic          ge;

  always_comb begin
    sh      = {rem_r, quo_r[DW-1]};
    ge      = (sh >= {1'b0, divisor});
    rem_nxt = ge ? SW'(sh - {1'b0, divisor}) : SW'(sh);
    quo_nxt = {quo_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: hw/rtl/per_state_running_mean_variance.sv
`default_nettype none
// Keeps a sample count, a Q16.16 running mean and a Q32.16 population variance for each
// queue status and returns the updated figures for every transfer whose status index is
// below NUM_STATUSES; other transfers are taken and dropped. One item is handled at a time,
// and no new transfer is taken until the last result is in the output register. Each item
// takes two division passes on bit-serial dividers: the mean and the squared deviation on
// two dividers side by side first, then the variance ratio. The statistics sit in one RAM;
// per-entry valid bits make every status read as empty straight after reset.
module per_state_running_mean_variance #(
  parameter int NUM_STATUSES = prmv_pkg::NUM_STATUSES_DEF,
  parameter int COUNT_BITS   = prmv_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // delay_sample
  input  wire logic [prmv_pkg::IN_DATA_W-1:0] in_tdata,
  // status_index
  input  wire logic [prmv_pkg::IDX_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // new_mean, new_variance, new_count, first_sample, statuses_seen, zero pad
  output logic      [prmv_pkg::OUT_W-1:0]     out_tdata
);

  import prmv_pkg::*;

  localparam int AW  = (NUM_STATUSES > 1) ? $clog2(NUM_STATUSES) : 1;
  localparam int CB  = COUNT_BITS;
  localparam int NPW = CB + 1;
  localparam int RW  = MEAN_W + VAR_W + CB;
  localparam int SW  = VAR_W + 1;
  localparam logic [CB-1:0] CNT_MAX = '1;

  state_t state_r, state_nxt;

  logic [AW-1:0]           addr_r;
  logic [DELAY_W-1:0]      delay_r;
  logic [NUM_STATUSES-1:0] valid_r;
  logic [MEAN_W-1:0]       m_r;
  logic [VAR_W-1:0]        v_r;
  logic [CB-1:0]           n_r;
  logic [MEAN_W+CB-1:0]    mn_r;
  logic [DIV_W-1:0]        d2_r;
  logic [MEAN_W-1:0]       nm_r;
  logic [SW-1:0]           s_r;
  logic [SEEN_W-1:0]       seen_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  logic              idx_ok;
  logic              in_acc;
  logic              ram_we;
  logic [RW-1:0]     ram_rdata;
  logic [RW-1:0]     ram_wdata;
  logic              start_a;
  logic              start_b;
  logic              done_a;
  logic              done_b;
  logic [DIV_W-1:0]  q_a;
  logic [DIV_W-1:0]  q_b;
  logic [DIV_W-1:0]  div_a_in;
  logic [DIV_W-1:0]  div_b_in;
  logic [NPW-1:0]    np1;
  logic [MEAN_W-1:0] x;
  logic [MEAN_W-1:0] dabs;
  logic [SW-1:0]     nv_full;
  logic [VAR_W-1:0]  nv;
  logic [CB-1:0]     n_new;
  logic              first;
  logic [SEEN_W-1:0] seen_new;
  logic              out_free;

  assign idx_ok    = (int'(in_tuser) < NUM_STATUSES);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  assign x        = {delay_r, {FRAC_W{1'b0}}};
  assign dabs     = (x >= m_r) ? (x - m_r) : (m_r - x);
  assign np1      = NPW'(n_r) + 1'b1;
  assign div_a_in = DIV_W'(mn_r) + DIV_W'(x);
  assign div_b_in = (state_r == ST_DIV1) ? d2_r : (DIV_W'(s_r) + DIV_W'(n_r));
  assign nv_full  = s_r - SW'(q_b);
  assign nv       = nv_full[SW-1] ? VAR_MAX : nv_full[VAR_W-1:0];
  assign first    = (n_r == '0);
  assign n_new    = (n_r == CNT_MAX) ? n_r : n_r + 1'b1;
  assign seen_new = (first && seen_r != SEEN_MAX) ? seen_r + 1'b1 : seen_r;
  assign ram_wdata = {n_new, nv, nm_r};

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    start_a   = 1'b0;
    start_b   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && idx_ok) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV1;
      ST_DIV1: begin
        start_a   = 1'b1;
        start_b   = 1'b1;
        state_nxt = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (done_a) begin
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        start_b   = 1'b1;
        state_nxt = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (done_b) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ram_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        valid_r[addr_r] <= 1'b1;
        seen_r          <= seen_new;
        out_valid_r     <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r  <= AW'(in_tuser);
      delay_r <= in_tdata[DELAY_W-1:0];
    end
    if (state_r == ST_READ) begin
      if (valid_r[addr_r]) begin
        m_r <= ram_rdata[MEAN_W-1:0];
        v_r <= ram_rdata[MEAN_W +: VAR_W];
        n_r <= ram_rdata[MEAN_W+VAR_W +: CB];
      end else begin
        m_r <= '0;
        v_r <= '0;
        n_r <= '0;
      end
    end
    if (state_r == ST_MUL) begin
      mn_r <= m_r * n_r;
      d2_r <= dabs * dabs;
    end
    if (state_r == ST_WAIT1 && done_a) begin
      nm_r <= q_a[MEAN_W-1:0];
      s_r  <= SW'(q_b[DIV_W-1:FRAC_W]) + SW'(v_r);
    end
    if (ram_we) begin
      out_data_r <= {{PAD_W{1'b0}}, seen_new, first, OUT_CNT_W'(n_new), nv, nm_r};
    end
  end

  prmv_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_STATUSES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (AW'(in_tuser)),
    .rdata (ram_rdata)
  );

  prmv_div #(
    .DW (DIV_W),
    .SW (NPW)
  ) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_a),
    .dividend (div_a_in),
    .divisor  (np1),
    .done     (done_a),
    .quotient (q_a)
  );

  prmv_div #(
    .DW (DIV_W),
    .SW (NPW)
  ) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_b),
    .dividend (div_b_in),
    .divisor  (np1),
    .done     (done_b),
    .quotient (q_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: hw/rtl/prmv_checker.sv
`default_nettype none
module prmv_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [prmv_pkg::OUT_W-1:0] out_tdata
);

  import prmv_pkg::*;

  logic first_out;

  assign first_out = out_tvalid && out_tdata[FIRST_BIT];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    first_out |-> out_tdata[CNT_LSB +: OUT_CNT_W] == OUT_CNT_W'(1))
    else $error("first sample without a count of one");

  a_first_var: assert property (@(posedge clk) disable iff (!rst_n)
    first_out |-> out_tdata[VAR_LSB +: VAR_W] == '0
                  && out_tdata[MEAN_LSB +: FRAC_W] == '0)
    else $error("first sample with non-zero variance or fraction");

  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SEEN_LSB +: SEEN_W] != '0)
    else $error("result with no status seen");

endmodule

bind per_state_running_mean_variance prmv_checker u_prmv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: bench/per_state_running_mean_variance_tb.sv
`timescale 1ns / 1ps
module per_state_running_mean_variance_tb;
  import prmv_pkg::*;

  localparam int NSTAT = 8;
  localparam int CNT_BITS = 24;
  localparam int N_RANDOM = 1650;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [SEEN_W-1:0]    seen;
    logic                 first;
    logic [OUT_CNT_W-1:0] count;
    logic [VAR_W-1:0]     variance;
    logic [MEAN_W-1:0]    mean;
  } stats_t;

  typedef struct {
    logic [IDX_W-1:0]   status;
    logic [DELAY_W-1:0] delay;
    logic               typed;
    stats_t             exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IDX_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  per_state_running_mean_variance i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  logic [63:0] mean_mdl [NSTAT];
  logic [63:0] var_mdl [NSTAT];
  logic [63:0] cnt_mdl [NSTAT];
  logic [3:0] seen_mdl;
  stats_t expected_stats [$];
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic stats_t update_stats(input logic [IDX_W-1:0] st,
                                          input logic [DELAY_W-1:0] dl);
    logic [63:0] n, m, v, np1, x, dabs, d2, a, s, nv, nm;
    stats_t r;
    n = cnt_mdl[st];
    m = mean_mdl[st];
    v = var_mdl[st];
    np1 = n + 64'd1;
    x = {48'd0, dl} << 16;
    nm = ((m * n + x) / np1) & 64'hFFFF_FFFF;
    dabs = (x >= m) ? x - m : m - x;
    d2 = dabs * dabs;
    a = (d2 / np1) >> 16;
    s = a + v;
    nv = s - (s + n) / np1;
    if (nv > 64'hFFFF_FFFF_FFFF) nv = 64'hFFFF_FFFF_FFFF;
    if (n == 0 && seen_mdl < 4'd15) seen_mdl = seen_mdl + 4'd1;
    mean_mdl[st] = nm;
    var_mdl[st] = nv;
    cnt_mdl[st] = (n < (64'd1 << CNT_BITS) - 1) ? np1 : n;
    r.mean = nm[MEAN_W-1:0];
    r.variance = nv[VAR_W-1:0];
    r.count = cnt_mdl[st][OUT_CNT_W-1:0];
    r.first = (n == 0);
    r.seen = seen_mdl;
    return r;
  endfunction

  task automatic send_sample(input logic [IDX_W-1:0] st, input logic [DELAY_W-1:0] dl,
                             input logic typed, input stats_t typed_exp);
    stats_t e;
    in_tuser <= st;
    in_tdata <= dl;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (st < NSTAT) begin
      e = update_stats(st, dl);
      if (typed && e !== typed_exp) begin
        $error("directed row %0d/%0d: predictor gives %h, table says %h", st, dl, e,
               typed_exp);
        errors++;
      end
      expected_stats.push_back(e);
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    stats_t got, e;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[SEEN_LSB+SEEN_W-1:0];
        if (expected_stats.size() == 0) begin
          $error("unexpected result transfer %h", got);
          errors++;
        end else begin
          e = expected_stats.pop_front();
          if (got.mean !== e.mean) begin
            $error("new_mean: expected %h, actual %h", e.mean, got.mean); errors++;
          end
          if (got.variance !== e.variance) begin
            $error("new_variance: expected %h, actual %h", e.variance, got.variance);
            errors++;
          end
          if (got.count !== e.count) begin
            $error("new_count: expected %0d, actual %0d", e.count, got.count); errors++;
          end
          if (got.first !== e.first) begin
            $error("first_sample: expected %b, actual %b", e.first, got.first); errors++;
          end
          if (got.seen !== e.seen) begin
            $error("statuses_seen: expected %0d, actual %0d", e.seen, got.seen); errors++;
          end
        end
      end
    end
  end

  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic stats_t mk(input logic [31:0] mn, input logic [47:0] vr,
                                input logic [23:0] cn, input logic fs, input logic [3:0] sn);
    stats_t r;
    r.mean = mn; r.variance = vr; r.count = cn; r.first = fs; r.seen = sn;
    return r;
  endfunction

  initial begin
    stim_row_t rows [$];
    int burst;
    int hot;
    int gap;
    for (int i = 0; i < NSTAT; i++) begin
      mean_mdl[i] = 0; var_mdl[i] = 0; cnt_mdl[i] = 0;
    end
    seen_mdl = 0;
    rows.push_back('{3'd0, 16'd0, 1'b1, mk(32'h0, 48'h0, 24'd1, 1'b1, 4'd1)});
    rows.push_back('{3'd7, 16'hFFFF, 1'b1, mk(32'hFFFF_0000, 48'h0, 24'd1, 1'b1, 4'd2)});
    rows.push_back('{3'd7, 16'd0, 1'b0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{3'd7, 16'hFFFF, 1'b0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{3'd0, 16'hFFFF, 1'b0, mk(0, 0, 0, 0, 0)});
    rows.push_back('{3'd0, 16'd0, 1'b0, mk(0, 0, 0, 0, 0)});
    for (int i = 1; i < 7; i++) begin
      rows.push_back('{i[2:0], 16'h5555 ^ i[15:0], 1'b0, mk(0, 0, 0, 0, 0)});
      rows.push_back('{i[2:0], 16'hAAAA, 1'b0, mk(0, 0, 0, 0, 0)});
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) send_sample(rows[i].status, rows[i].delay, rows[i].typed, rows[i].exp);
    in_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    hot = $urandom_range(0, NSTAT - 1);
    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && i < N_RANDOM; b++, i++) begin
        case ($urandom_range(0, 9))
          0: send_sample(hot[2:0], $urandom_range(0, 1) ? 16'hFFFF : 16'h0, 1'b0, '0);
          1, 2: send_sample(hot[2:0], DELAY_W'($urandom), 1'b0, '0);
          3: send_sample(IDX_W'($urandom),
                         $urandom_range(0, 1) ? 16'hFFFF : DELAY_W'($urandom), 1'b0, '0);
          default: send_sample(IDX_W'($urandom), DELAY_W'($urandom), 1'b0, '0);
        endcase
        if (i == N_RANDOM / 2) begin
          in_tvalid <= 1'b0;
          while (expected_stats.size() != 0) @(negedge clk);
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0 && expected_stats.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
